/* rtl/mpsc_pkg.sv */
// ----------------------------------------------------------------------------
// mpsc_pkg: shared types, constants and helpers
// Fixed-point format, register indexes, reset values and saturating helpers
// for the Mandelbrot smooth-color pixel unit.
// ----------------------------------------------------------------------------
package mpsc_pkg;

    localparam int FRAC_BITS        = 60;
    localparam int PIXEL_INDEX_BITS = 12;
    localparam int PIX_IN_W         = 12;
    localparam int IDX_W            = (PIXEL_INDEX_BITS < PIX_IN_W) ?
                                      PIXEL_INDEX_BITS : PIX_IN_W;
    localparam int LOG_FRAC         = 16;
    localparam int LOG_CNT_W        = $clog2(LOG_FRAC);
    localparam int QDEPTH           = 2;
    localparam int QPTR_W           = $clog2(QDEPTH);

    // Register indexes on the configuration port
    localparam logic [2:0] REG_CORNER_RE   = 3'd0;
    localparam logic [2:0] REG_CORNER_IM   = 3'd1;
    localparam logic [2:0] REG_PIXEL_STEP  = 3'd2;
    localparam logic [2:0] REG_MAX_ITER    = 3'd3;
    localparam logic [2:0] REG_COLOR_SCALE = 3'd4;
    localparam logic [2:0] REG_OFFSET_RED  = 3'd5;
    localparam logic [2:0] REG_OFFSET_GRN  = 3'd6;
    localparam logic [2:0] REG_OFFSET_BLU  = 3'd7;

    localparam logic [15:0]       RST_MAX_ITER    = 16'd5000;
    localparam logic [23:0]       RST_COLOR_SCALE = 24'd1365393;
    localparam logic signed [8:0] RST_OFFSET_RED  = 9'sd30;
    localparam logic signed [8:0] RST_OFFSET_GRN  = -9'sd80;
    localparam logic signed [8:0] RST_OFFSET_BLU  = 9'sd80;

    // 1.75 in Q.16
    localparam logic signed [33:0] SMOOTH_BIAS = 34'sd114688;

    typedef struct packed {
        logic signed [63:0] re;
        logic signed [63:0] im;
    } t_point;

    typedef struct packed {
        logic        valid;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic         valid;
        logic [127:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic       done;
        logic [6:0] e;
        logic [15:0] frac;
    } t_log_rsp;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add = s[63:0];
        end
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] a);
        abs64 = a[63] ? 64'(-a) : 64'(a);
    endfunction

endpackage

/* rtl/mpsc_front.sv */
// ----------------------------------------------------------------------------
// mpsc_front: pixel to point mapping
// Accepts pixel items, multiplies the indexes by the step and adds the
// corner with saturation, then pushes the point into the queue.
// ----------------------------------------------------------------------------
module mpsc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mpsc_pkg::PIX_IN_W-1:0] i_col,
    input  logic [mpsc_pkg::PIX_IN_W-1:0] i_row,
    input  logic signed [63:0]         i_corner_re,
    input  logic signed [63:0]         i_corner_im,
    input  logic [62:0]                i_step,
    output logic                       o_push_valid,
    input  logic                       i_push_ready,
    output mpsc_pkg::t_point           o_point
);
    import mpsc_pkg::*;

    logic                r_av;
    logic [IDX_W+62:0]   r_pc;
    logic [IDX_W+62:0]   r_pr;
    logic signed [63:0]  off_re;
    logic signed [63:0]  off_im;

    assign o_ready = !r_av || i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (o_ready) begin
            r_av <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_pc <= {63'd0, i_col[IDX_W-1:0]} * {{IDX_W{1'b0}}, i_step};
            r_pr <= {63'd0, i_row[IDX_W-1:0]} * {{IDX_W{1'b0}}, i_step};
        end
    end

    // clamp the offset to the positive 64-bit range
    assign off_re = (|r_pc[IDX_W+62:63]) ? {1'b0, {63{1'b1}}} : {1'b0, r_pc[62:0]};
    assign off_im = (|r_pr[IDX_W+62:63]) ? {1'b0, {63{1'b1}}} : {1'b0, r_pr[62:0]};

    assign o_push_valid = r_av;
    assign o_point.re   = sat_add(i_corner_re, off_re);
    assign o_point.im   = sat_add(i_corner_im, off_im);

endmodule

/* rtl/mpsc_queue.sv */
// ----------------------------------------------------------------------------
// mpsc_queue: point queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module mpsc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  mpsc_pkg::t_point i_point,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output mpsc_pkg::t_point o_point
);
    import mpsc_pkg::*;

    t_point            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_point      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
        if (push) r_mem[r_wp] <= i_point;
    end

endmodule

/* rtl/mpsc_mul64.sv */
// ----------------------------------------------------------------------------
// mpsc_mul64: pipelined 64x64 unsigned multiplier
// Four 32x32 partial products in the first stage, their sum in the second.
// ----------------------------------------------------------------------------
module mpsc_mul64 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpsc_pkg::t_mul_req i_req,
    output mpsc_pkg::t_mul_rsp o_rsp
);
    import mpsc_pkg::*;

    logic         r_v1;
    logic         r_v2;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_prod;
    logic [64:0]  mid;

    assign mid = {1'b0, r_p01} + {1'b0, r_p10};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
        end
        r_p00  <= i_req.a[31:0]  * i_req.b[31:0];
        r_p01  <= i_req.a[31:0]  * i_req.b[63:32];
        r_p10  <= i_req.a[63:32] * i_req.b[31:0];
        r_p11  <= i_req.a[63:32] * i_req.b[63:32];
        r_prod <= {r_p11, r_p00} + {31'd0, mid, 32'd0};
    end

    assign o_rsp.valid = r_v2;
    assign o_rsp.prod  = r_prod;

endmodule

/* rtl/mpsc_log2.sv */
// ----------------------------------------------------------------------------
// mpsc_log2: iterative base-2 logarithm
// Normalizes a 128-bit value a byte or a bit per cycle, then builds the
// fraction one bit per cycle by squaring a Q1.30 mantissa.
// ----------------------------------------------------------------------------
module mpsc_log2 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [127:0]       i_x,
    output mpsc_pkg::t_log_rsp o_rsp
);
    import mpsc_pkg::*;

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} t_lst;

    t_lst                 r_st;
    logic                 r_done;
    logic [127:0]         r_x;
    logic [6:0]           r_e;
    logic [30:0]          r_m;
    logic [LOG_FRAC-1:0]  r_frac;
    logic [LOG_CNT_W-1:0] r_cnt;
    logic [61:0]          sq;
    logic [31:0]          t;

    assign sq = {31'd0, r_m} * {31'd0, r_m};
    assign t  = sq[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_st == L_SQ) && (r_cnt == LOG_CNT_W'(LOG_FRAC-1));
            case (r_st)
                L_IDLE: begin
                    if (i_start) begin
                        r_x    <= (i_x == '0) ? 128'd1 : i_x;
                        r_e    <= 7'd127;
                        r_frac <= '0;
                        r_cnt  <= '0;
                        r_st   <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (r_x[127]) begin
                        r_m  <= r_x[127:97];
                        r_st <= L_SQ;
                    end else if (r_x[127:120] == 8'd0) begin
                        r_x <= r_x << 8;
                        r_e <= r_e - 7'd8;
                    end else begin
                        r_x <= r_x << 1;
                        r_e <= r_e - 7'd1;
                    end
                end
                L_SQ: begin
                    r_m    <= t[31] ? t[31:1] : t[30:0];
                    r_frac <= {r_frac[LOG_FRAC-2:0], t[31]};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == LOG_CNT_W'(LOG_FRAC-1)) begin
                        r_st <= L_IDLE;
                    end
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.e    = r_e;
    assign o_rsp.frac = r_frac;

endmodule

/* rtl/mpsc_back.sv */
// ----------------------------------------------------------------------------
// mpsc_back: escape iteration and smooth coloring
// Sequences the iteration over the shared multiplier, then for an escaped pixel
// the three logarithms and the color scaling; holds the result register.
// ----------------------------------------------------------------------------
module mpsc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  mpsc_pkg::t_point   i_point,
    input  logic [15:0]        i_max_iter,
    input  logic [23:0]        i_scale,
    input  logic signed [8:0]  i_off_red,
    input  logic signed [8:0]  i_off_grn,
    input  logic signed [8:0]  i_off_blu,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [15:0]        o_count,
    output logic               o_inside
);
    import mpsc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MP, ST_WP, ST_UPD, ST_MR, ST_MI, ST_WR, ST_WI, ST_SUM,
        ST_TST, ST_L1, ST_W1, ST_L2, ST_W2, ST_V, ST_L3, ST_W3, ST_SC,
        ST_CH, ST_DONE
    } t_state;

    localparam int TLIM = 2 * FRAC_BITS + 2;

    t_state              r_st;
    logic signed [63:0]  r_cr, r_ci, r_zr, r_zi, r_d, r_ps;
    logic [127:0]        r_sqr, r_sqi, r_raw;
    logic [15:0]         r_it, r_lim;
    logic [20:0]         r_w;
    logic [22:0]         r_llz;
    logic signed [33:0]  r_v;
    logic signed [22:0]  r_lv;
    logic signed [47:0]  r_prod;
    logic                r_inside;
    logic                r_inside_q;
    logic                r_ovalid;
    logic [7:0]          r_red, r_grn, r_blu;
    logic [15:0]         r_cnt;

    t_mul_req            mreq;
    t_mul_rsp            mrsp;
    logic                lstart;
    logic [127:0]        lx;
    t_log_rsp            lrsp;

    logic [63:0]         a_cl, b_cl, p_cl;
    logic                escaped;
    logic [7:0]          le1;
    logic [6:0]          le2, le3;
    logic signed [15:0]  base;

    mpsc_mul64 u_mul (.i_clk, .i_rst_n, .i_req(mreq), .o_rsp(mrsp));
    mpsc_log2  u_log (.i_clk, .i_rst_n, .i_start(lstart), .i_x(lx), .o_rsp(lrsp));

    // multiplier requests
    always_comb begin
        mreq.valid = 1'b0;
        mreq.a     = abs64(r_zr);
        mreq.b     = abs64(r_zi);
        case (r_st)
            ST_MP: mreq.valid = 1'b1;
            ST_MR: begin
                mreq.valid = 1'b1;
                mreq.b     = abs64(r_zr);
            end
            ST_MI: begin
                mreq.valid = 1'b1;
                mreq.a     = abs64(r_zi);
            end
            default: mreq.valid = 1'b0;
        endcase
    end

    always_comb begin
        lstart = 1'b0;
        lx     = r_raw;
        case (r_st)
            ST_L1: lstart = 1'b1;
            ST_L2: begin
                lstart = 1'b1;
                lx     = {107'd0, r_w};
            end
            ST_L3: begin
                lstart = 1'b1;
                lx     = (r_v < 34'sd1) ? 128'd1 : {94'd0, r_v};
            end
            default: lstart = 1'b0;
        endcase
    end

    // truncated magnitudes clamped to the positive 64-bit range
    assign a_cl = (|r_sqr[127:FRAC_BITS+63]) ? {1'b0, {63{1'b1}}}
                                             : {1'b0, r_sqr[FRAC_BITS+62:FRAC_BITS]};
    assign b_cl = (|r_sqi[127:FRAC_BITS+63]) ? {1'b0, {63{1'b1}}}
                                             : {1'b0, r_sqi[FRAC_BITS+62:FRAC_BITS]};
    assign p_cl = (|mrsp.prod[127:FRAC_BITS+62]) ? {1'b0, {63{1'b1}}}
                                                 : {1'b0, mrsp.prod[FRAC_BITS+61:FRAC_BITS-1]};

    // |z|^2 strictly above four
    assign escaped = (|r_raw[127:TLIM+1]) || (r_raw[TLIM] && (|r_raw[TLIM-1:0]));

    assign le1  = {1'b0, lrsp.e} - 8'(2 * FRAC_BITS);
    assign le2  = lrsp.e - 7'(LOG_FRAC);
    assign le3  = lrsp.e - 7'(LOG_FRAC);
    assign base = r_prod[47:32];

    function automatic logic [7:0] chan(input logic signed [15:0] b,
                                        input logic signed [8:0] off);
        logic signed [16:0] v;
        v = {b[15], b} + {{8{off[8]}}, off};
        if (v < 17'sd0)        chan = 8'd0;
        else if (v > 17'sd255) chan = 8'd255;
        else                   chan = v[7:0];
    endfunction

    assign o_pop_ready = (r_st == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_st == ST_DONE && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready)                  r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_pop_valid) begin
                        r_cr  <= i_point.re;
                        r_ci  <= i_point.im;
                        r_zr  <= '0;
                        r_zi  <= '0;
                        r_sqr <= '0;
                        r_sqi <= '0;
                        r_it  <= '0;
                        r_lim <= i_max_iter;
                        if (i_max_iter == 16'd0) begin
                            r_inside <= 1'b1;
                            r_st     <= ST_DONE;
                        end else begin
                            r_st <= ST_MP;
                        end
                    end
                end
                ST_MP: r_st <= ST_WP;
                ST_WP: begin
                    if (mrsp.valid) begin
                        r_d  <= a_cl - b_cl;
                        r_ps <= (r_zr[63] != r_zi[63]) ? -p_cl : p_cl;
                        r_st <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_zr <= sat_add(r_d, r_cr);
                    r_zi <= sat_add(r_ps, r_ci);
                    r_st <= ST_MR;
                end
                ST_MR: r_st <= ST_MI;
                ST_MI: r_st <= ST_WR;
                ST_WR: begin
                    if (mrsp.valid) begin
                        r_sqr <= mrsp.prod;
                        r_st  <= ST_WI;
                    end
                end
                ST_WI: begin
                    if (mrsp.valid) begin
                        r_sqi <= mrsp.prod;
                        r_st  <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_raw <= r_sqr + r_sqi;
                    r_st  <= ST_TST;
                end
                ST_TST: begin
                    if (escaped) begin
                        r_inside <= 1'b0;
                        r_st     <= ST_L1;
                    end else if (r_it + 16'd1 == r_lim) begin
                        r_it     <= r_lim;
                        r_inside <= 1'b1;
                        r_st     <= ST_DONE;
                    end else begin
                        r_it <= r_it + 16'd1;
                        r_st <= ST_MP;
                    end
                end
                ST_L1: r_st <= ST_W1;
                ST_W1: begin
                    if (lrsp.done) begin
                        r_w  <= {le1[5:0], lrsp.frac[15:1]};
                        r_st <= ST_L2;
                    end
                end
                ST_L2: r_st <= ST_W2;
                ST_W2: begin
                    if (lrsp.done) begin
                        r_llz <= {le2, lrsp.frac};
                        r_st  <= ST_V;
                    end
                end
                ST_V: begin
                    r_v  <= $signed({2'b00, r_it, 16'd0}) + SMOOTH_BIAS
                            - $signed({11'd0, r_llz});
                    r_st <= ST_L3;
                end
                ST_L3: r_st <= ST_W3;
                ST_W3: begin
                    if (lrsp.done) begin
                        r_lv <= {le3, lrsp.frac};
                        r_st <= ST_SC;
                    end
                end
                ST_SC: begin
                    r_prod <= $signed({1'b0, i_scale}) * r_lv;
                    r_st   <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_cnt    <= r_it;
                        if (r_inside) begin
                            r_red <= 8'd0;
                            r_grn <= 8'd0;
                            r_blu <= 8'd0;
                        end else begin
                            r_red <= chan(base, i_off_red);
                            r_grn <= chan(base, i_off_grn);
                            r_blu <= chan(base, i_off_blu);
                        end
                        r_st <= ST_CH;
                    end
                end
                ST_CH: r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_red    = r_red;
    assign o_green  = r_grn;
    assign o_blue   = r_blu;
    assign o_count  = r_cnt;
    assign o_inside = r_inside_q;

    always_ff @(posedge i_clk) begin
        if (r_st == ST_DONE && (!r_ovalid || i_ready)) r_inside_q <= r_inside;
    end

endmodule

/* rtl/mandelbrot_pixel_smooth_color_unit.sv */
// ----------------------------------------------------------------------------
// mandelbrot_pixel_smooth_color_unit: escape-time pixel with smooth color
// Maps a pixel to a point, iterates z = z*z + c and colors the result.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one item per pixel (column, row). The front maps
//   it to c = corner + index * step and queues it (two entries), so input
//   is taken while the back still iterates on an earlier pixel.
//   Output stream m_axis_*: one item per pixel with red, green, blue and the
//   iteration count in tdata and the inside flag in tuser.
//   Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
//   high; write only while no pixel is in flight.
//   Pacing: one pixel at a time in the back. Each iteration is paced by
//   the shared two-stage 64x64 multiplier (three products per iteration).
//   An escaped pixel adds three logarithms, each normalizing its input and
//   then squaring the mantissa once per fraction bit; an inside pixel goes
//   straight from the last iteration to the result.
//   From acceptance, a pixel passes the front register and the queue
//   before the back takes it.
//   Reset clears the control state and loads the register defaults.
//   A stalled receiver holds the result; the queue and then the front
//   register keep filling until full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_smooth_color_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [11:0] pixel_col, [23:12] pixel_row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] red, [15:8] green,
                                        // [23:16] blue, [39:24] iteration_count
    output logic        m_axis_tuser,   // [0] inside_set
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import mpsc_pkg::*;

    logic signed [63:0] r_corner_re, r_corner_im;
    logic [62:0]        r_step;
    logic [15:0]        r_max_iter;
    logic [23:0]        r_scale;
    logic signed [8:0]  r_off_red, r_off_grn, r_off_blu;

    logic   push_valid, push_ready, pop_valid, pop_ready;
    t_point push_pt, pop_pt;
    logic [7:0]  red, green, blue;
    logic [15:0] count;
    logic        in_set;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_re <= '0;
            r_corner_im <= '0;
            r_step      <= '0;
            r_max_iter  <= RST_MAX_ITER;
            r_scale     <= RST_COLOR_SCALE;
            r_off_red   <= RST_OFFSET_RED;
            r_off_grn   <= RST_OFFSET_GRN;
            r_off_blu   <= RST_OFFSET_BLU;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CORNER_RE:   r_corner_re <= i_cfg_data;
                REG_CORNER_IM:   r_corner_im <= i_cfg_data;
                REG_PIXEL_STEP:  r_step      <= i_cfg_data[62:0];
                REG_MAX_ITER:    r_max_iter  <= i_cfg_data[15:0];
                REG_COLOR_SCALE: r_scale     <= i_cfg_data[23:0];
                REG_OFFSET_RED:  r_off_red   <= i_cfg_data[8:0];
                REG_OFFSET_GRN:  r_off_grn   <= i_cfg_data[8:0];
                REG_OFFSET_BLU:  r_off_blu   <= i_cfg_data[8:0];
                default:         r_off_blu   <= r_off_blu;
            endcase
        end
    end

    // front: accept pixels and map them to points
    mpsc_front u_front (
        .i_clk, .i_rst_n,
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_col        (s_axis_tdata[11:0]),
        .i_row        (s_axis_tdata[23:12]),
        .i_corner_re  (r_corner_re),
        .i_corner_im  (r_corner_im),
        .i_step       (r_step),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_point      (push_pt)
    );

    // hold points between the front and the back
    mpsc_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_point      (push_pt),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_point      (pop_pt)
    );

    // back: iterate, take logarithms, scale and clamp the channels
    mpsc_back u_back (
        .i_clk, .i_rst_n,
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_point     (pop_pt),
        .i_max_iter  (r_max_iter),
        .i_scale     (r_scale),
        .i_off_red   (r_off_red),
        .i_off_grn   (r_off_grn),
        .i_off_blu   (r_off_blu),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_red       (red),
        .o_green     (green),
        .o_blue      (blue),
        .o_count     (count),
        .o_inside    (in_set)
    );

    assign m_axis_tdata = {count, blue, green, red};
    assign m_axis_tuser = in_set;

endmodule

/* dv/tb_mandelbrot_pixel_smooth_color_unit.sv */
// ----------------------------------------------------------------------------
// tb_mandelbrot_pixel_smooth_color_unit: self-checking pixel unit testbench
// Drives pixel items through the input stream under several register
// settings. A bit-exact fixed-point model predicts every output item. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------
import mpsc_pkg::*;

typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] iters;
    logic        in_set;
} t_pixel_color;

class pixel_scoreboard;
    // Mirror of the configuration registers
    longint      corner_re;
    longint      corner_im;
    logic [62:0] step;
    logic [15:0] max_iter;
    logic [23:0] color_scale;
    logic [8:0]  offset[3];
    t_pixel_color pending[$];
    int          errors;

    function new();
        corner_re   = 0;
        corner_im   = 0;
        step        = '0;
        max_iter    = RST_MAX_ITER;
        color_scale = RST_COLOR_SCALE;
        offset[0]   = RST_OFFSET_RED;
        offset[1]   = RST_OFFSET_GRN;
        offset[2]   = RST_OFFSET_BLU;
        errors      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
        case (idx)
            REG_CORNER_RE:   corner_re   = data;
            REG_CORNER_IM:   corner_im   = data;
            REG_PIXEL_STEP:  step        = data[62:0];
            REG_MAX_ITER:    max_iter    = data[15:0];
            REG_COLOR_SCALE: color_scale = data[23:0];
            REG_OFFSET_RED:  offset[0]   = data[8:0];
            REG_OFFSET_GRN:  offset[1]   = data[8:0];
            REG_OFFSET_BLU:  offset[2]   = data[8:0];
            default: ;
        endcase
    endfunction

    function logic [63:0] mag(longint a);
        logic [63:0] r;
        r = a;
        if (a < 0) r = -r;
        return r;
    endfunction

    function longint sat_sum(longint a, longint b);
        longint r;
        r = a + b;
        if (a >= 0 && b >= 0 && r < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (a < 0 && b < 0 && r >= 0) return 64'h8000_0000_0000_0000;
        return r;
    endfunction

    function longint clamp_pos(logic [127:0] p);
        if (p > 128'h7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
        return p[63:0];
    endfunction

    function logic [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
        return {64'd0, a} * {64'd0, b};
    endfunction

    // Truncate the magnitude of the product, then apply the sign
    function longint fix_mul(longint a, longint b, int sh);
        longint m;
        m = clamp_pos(wide_mul(mag(a), mag(b)) >> sh);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // log2 of x * 2^-q in Q.16 by repeated squaring of a Q1.30 mantissa
    function longint log2_q16(logic [127:0] x, int q);
        int          e;
        logic [63:0] m;
        logic [15:0] frac;
        if (x == 0) x = 1;
        e = 0;
        for (int k = 127; k > 0; k--) begin
            if (x[k] && e == 0) e = k;
        end
        if (e >= 30) m = 64'(x >> (e - 30));
        else m = x[63:0] << (30 - e);
        frac = 0;
        for (int k = 0; k < LOG_FRAC; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'(e - q) * 65536 + longint'(frac);
    endfunction

    function logic [7:0] clamp_channel(longint base, logic [8:0] off);
        longint v;
        v = base + longint'($signed(off));
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function t_pixel_color color_of(logic [11:0] col, logic [11:0] row);
        t_pixel_color r;
        longint cr, ci, zr, zi, a, b, p, lz2, llz, v, lv, prod, base;
        logic [127:0] raw;
        int i;
        cr = sat_sum(corner_re, clamp_pos(wide_mul(64'(col), 64'(step))));
        ci = sat_sum(corner_im, clamp_pos(wide_mul(64'(row), 64'(step))));
        zr = 0;
        zi = 0;
        raw = 0;
        for (i = 0; i < int'(max_iter); i++) begin
            a = fix_mul(zr, zr, FRAC_BITS);
            b = fix_mul(zi, zi, FRAC_BITS);
            p = fix_mul(zr, zi, FRAC_BITS - 1);
            zr = sat_sum(a - b, cr);
            zi = sat_sum(p, ci);
            raw = wide_mul(mag(zr), mag(zr)) + wide_mul(mag(zi), mag(zi));
            if (raw > (128'd1 << (2 * FRAC_BITS + 2))) break;
        end
        if (i == int'(max_iter)) begin
            r.red = 0; r.green = 0; r.blue = 0;
            r.iters = max_iter;
            r.in_set = 1'b1;
        end else begin
            lz2 = log2_q16(raw, 2 * FRAC_BITS);
            llz = log2_q16(128'(lz2 >>> 1), LOG_FRAC);
            v = longint'(i) * 65536 + 7 * 16384 - llz;
            // Raise a non-positive smooth argument to the smallest step
            if (v < 1) v = 1;
            lv = log2_q16(128'(v), LOG_FRAC);
            prod = longint'(color_scale) * lv;
            if (prod >= 0) base = prod >>> 32;
            else base = -longint'((mag(prod) + 64'hFFFF_FFFF) >> 32);
            r.red    = clamp_channel(base, offset[0]);
            r.green  = clamp_channel(base, offset[1]);
            r.blue   = clamp_channel(base, offset[2]);
            r.iters  = i[15:0];
            r.in_set = 1'b0;
        end
        return r;
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row);
        pending.push_back(color_of(col, row));
    endfunction

    function void check_color(t_pixel_color got);
        t_pixel_color want;
        if (pending.size() == 0) begin
            $error("unexpected output item");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            errors++;
        end
        if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            errors++;
        end
        if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            errors++;
        end
        if (got.iters !== want.iters) begin
            $error("iteration_count: expected %0d, got %0d", want.iters, got.iters);
            errors++;
        end
        if (got.in_set !== want.in_set) begin
            $error("inside_set: expected %0d, got %0d", want.in_set, got.in_set);
            errors++;
        end
    endfunction
endclass

module tb_mandelbrot_pixel_smooth_color_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    pixel_scoreboard colors = new();
    // When set, neither side idles: back-to-back items
    bit no_gaps = 0;
    int ready_hold = 0;

    mandelbrot_pixel_smooth_color_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: check each accepted item, then stall a random while
    always @(posedge i_clk) begin
        t_pixel_color got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.red    = m_axis_tdata[7:0];
                got.green  = m_axis_tdata[15:8];
                got.blue   = m_axis_tdata[23:16];
                got.iters  = m_axis_tdata[39:24];
                got.in_set = m_axis_tuser;
                colors.check_color(got);
                ready_hold = no_gaps ? 0 : $urandom_range(0, 13);
            end
            if (ready_hold > 0) begin
                m_axis_tready <= 1'b0;
                ready_hold--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Write one register; the caller drops the write enable after a batch
    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        colors.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic write_all(longint re, longint im, logic [62:0] stp, logic [15:0] iters,
                             logic [23:0] scale, int red, int grn, int blu);
        write_reg(REG_CORNER_RE, re);
        write_reg(REG_CORNER_IM, im);
        write_reg(REG_PIXEL_STEP, {1'b0, stp});
        write_reg(REG_MAX_ITER, {48'd0, iters});
        write_reg(REG_COLOR_SCALE, {40'd0, scale});
        write_reg(REG_OFFSET_RED, 64'(red));
        write_reg(REG_OFFSET_GRN, 64'(grn));
        write_reg(REG_OFFSET_BLU, 64'(blu));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Idle a random while, then hold the item until it is taken
    task automatic send_pixel(logic [11:0] col, logic [11:0] row);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        colors.note_pixel(col, row);
    endtask

    // Drop valid, then wait until every output item has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (colors.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        longint re, im;
        logic [62:0] stp;
        int sh;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: the origin stays inside for the full limit
        send_pixel(12'd0, 12'd0);
        drain();

        // Whole set in view, strongest scale and extreme offsets
        write_all(-(64'sd2 <<< 60), -(64'sd3 <<< 59), 63'(1) << 50, 16'd32,
                  24'hFFFFFF, 255, -255, 0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd1280, 12'd1536);
        send_pixel(12'd2000, 12'd1300);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain();

        // Zero iteration limit: every pixel inside at once
        write_all(64'sd0, 64'sd0, 63'd0, 16'd0, 24'd0, -255, 255, -1);
        send_pixel(12'd7, 12'd9);
        send_pixel(12'hFFF, 12'hFFF);
        drain();

        // Large pixel offset saturates; escape is immediate so the top
        // limit stays cheap and the smooth argument goes non-positive
        write_all(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, {63{1'b1}},
                  16'hFFFF, 24'd0, -255, 0, 255);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'hFFF);
        drain();
        write_all(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, {63{1'b1}},
                  16'hFFFF, 24'd1365393, 30, -80, 80);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd0, 12'd0);
        drain();

        // Single step limit near the boundary
        write_all(-(64'sd3 <<< 58), 64'sd0, 63'd1, 16'd1, 24'd1365393, 30, -80, 80);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        drain();

        // Random phases: mostly views of the set, sometimes wild registers
        for (int ph = 0; ph < 20; ph++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                re = {$urandom, $urandom};
                im = {$urandom, $urandom};
                sh = $urandom_range(0, 62);
            end else begin
                re = longint'({$urandom, $urandom}) >>> 2;
                im = longint'({$urandom, $urandom}) >>> 2;
                sh = $urandom_range(12, 40);
            end
            stp = 63'({$urandom, $urandom} >> (sh + 1));
            write_all(re, im, stp, 16'($urandom_range(1, 48)), 24'($urandom),
                      $urandom_range(0, 510) - 255, $urandom_range(0, 510) - 255,
                      $urandom_range(0, 510) - 255);
            for (int n = 0; n < 39; n++) begin
                send_pixel(12'($urandom), 12'($urandom));
            end
            drain();
        end
        no_gaps = 0;
        repeat (200) @(posedge i_clk);

        if (colors.errors == 0 && colors.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40000000;
        $display("tb: failure");
        $finish;
    end

endmodule
